// ===== sv/owsid_pkg.sv =====
`default_nettype none

package owsid_pkg;

    localparam int unsigned ID_BYTES   = 8;
    localparam int unsigned TMR_W      = 10;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 64;

    localparam logic [CFG_ADDR_W-1:0] CFG_SAMPLE_DELAY    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_READ_HOLD       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RESET_LOW_MIN   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESENCE_WAIT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_PRESENCE_LENGTH = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_READ_ROM_OPCODE = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_ID_CODE         = 3'd6;

    localparam logic [TMR_W-1:0] RST_SAMPLE_DELAY    = 10'd30;
    localparam logic [TMR_W-1:0] RST_READ_HOLD       = 10'd30;
    localparam logic [TMR_W-1:0] RST_RESET_LOW_MIN   = 10'd480;
    localparam logic [TMR_W-1:0] RST_PRESENCE_WAIT   = 10'd30;
    localparam logic [TMR_W-1:0] RST_PRESENCE_LENGTH = 10'd120;
    localparam logic [7:0]       RST_READ_ROM_OPCODE = 8'd51;

    localparam logic [7:0] IDLE_BYTE   = 8'hFF;
    localparam logic [3:0] BITS_BYTE   = 4'd8;
    localparam logic [3:0] BYTE_CNT_MAX = 4'd15;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_RESET = 3'd1,
        PH_PWAIT = 3'd2,
        PH_PRES  = 3'd3,
        PH_CMD   = 3'd4,
        PH_ROM   = 3'd5
    } phase_t;

    typedef struct packed {
        logic [TMR_W-1:0] sample_delay;
        logic [TMR_W-1:0] read_hold;
        logic [TMR_W-1:0] reset_low_min;
        logic [TMR_W-1:0] presence_wait;
        logic [TMR_W-1:0] presence_length;
        logic [7:0]       read_rom_opcode;
        logic [63:0]      id_code;
    } cfg_t;

    typedef struct packed {
        logic   line_out;
        phase_t phase;
    } result_t;

    function automatic logic [TMR_W-1:0] load_val(input logic [TMR_W-1:0] v);
        return (v == '0) ? TMR_W'(1) : v;
    endfunction

endpackage

`default_nettype wire

// ===== sv/owsid_cfg.sv =====
`default_nettype none

module owsid_cfg (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [owsid_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [owsid_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output owsid_pkg::cfg_t                       cfg
);
    import owsid_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sample_delay    <= RST_SAMPLE_DELAY;
            cfg_reg.read_hold       <= RST_READ_HOLD;
            cfg_reg.reset_low_min   <= RST_RESET_LOW_MIN;
            cfg_reg.presence_wait   <= RST_PRESENCE_WAIT;
            cfg_reg.presence_length <= RST_PRESENCE_LENGTH;
            cfg_reg.read_rom_opcode <= RST_READ_ROM_OPCODE;
            cfg_reg.id_code         <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_SAMPLE_DELAY:    cfg_reg.sample_delay    <= cfg_wdata[TMR_W-1:0];
                CFG_READ_HOLD:       cfg_reg.read_hold       <= cfg_wdata[TMR_W-1:0];
                CFG_RESET_LOW_MIN:   cfg_reg.reset_low_min   <= cfg_wdata[TMR_W-1:0];
                CFG_PRESENCE_WAIT:   cfg_reg.presence_wait   <= cfg_wdata[TMR_W-1:0];
                CFG_PRESENCE_LENGTH: cfg_reg.presence_length <= cfg_wdata[TMR_W-1:0];
                CFG_READ_ROM_OPCODE: cfg_reg.read_rom_opcode <= cfg_wdata[7:0];
                CFG_ID_CODE:         cfg_reg.id_code         <= cfg_wdata[63:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== sv/owsid_core.sv =====
`default_nettype none

module owsid_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_xfer,
    input  wire logic          line_in,
    input  wire owsid_pkg::cfg_t cfg,
    output owsid_pkg::result_t res
);
    import owsid_pkg::*;

    phase_t           phase_reg, phase_next, phase_fire;
    logic [3:0]       bit_reg, bit_next;
    logic [3:0]       byte_reg, byte_next;
    logic [7:0]       shift_reg, shift_next;
    logic             last_reg, last_next;
    logic             drive_reg, drive_next;
    logic [TMR_W-1:0] main_tmr_reg, main_tmr_next;
    logic [TMR_W-1:0] rst_tmr_reg, rst_tmr_next;
    logic [2:0]       byte_idx;
    logic [7:0]       id_byte;

    always_comb
    begin
        phase_next    = phase_reg;
        bit_next      = bit_reg;
        byte_next     = byte_reg;
        shift_next    = shift_reg;
        drive_next    = drive_reg;
        main_tmr_next = main_tmr_reg;
        rst_tmr_next  = rst_tmr_reg;
        last_next     = line_in;

        // reset timer first, then main timer
        if (rst_tmr_reg != '0)
        begin
            rst_tmr_next = rst_tmr_reg - TMR_W'(1);
            if (rst_tmr_next == '0)
                phase_next = PH_RESET;
        end

        phase_fire = phase_next;
        if (main_tmr_reg != '0)
        begin
            main_tmr_next = main_tmr_reg - TMR_W'(1);
            if (main_tmr_next == '0)
            begin
                unique case (phase_fire)
                    PH_PWAIT:
                    begin
                        drive_next    = 1'b0;
                        phase_next    = PH_PRES;
                        main_tmr_next = load_val(cfg.presence_length);
                    end
                    PH_PRES:
                    begin
                        drive_next = 1'b1;
                        bit_next   = '0;
                        shift_next = '0;
                        phase_next = PH_CMD;
                    end
                    PH_CMD:
                    begin
                        shift_next = {last_reg, shift_reg[7:1]};
                        bit_next   = bit_reg + 4'd1;
                        if (bit_next == BITS_BYTE)
                        begin
                            if (shift_next == cfg.read_rom_opcode)
                            begin
                                bit_next   = '0;
                                byte_next  = '0;
                                phase_next = PH_ROM;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                    PH_ROM:
                    begin
                        drive_next = 1'b1;
                        if (byte_reg == 4'(ID_BYTES))
                            phase_next = PH_IDLE;
                    end
                    default: ;
                endcase
            end
        end

        // sent first: highest byte
        byte_idx = 3'(ID_BYTES - 1) - byte_next[2:0];
        id_byte  = cfg.id_code[byte_idx*8 +: 8];

        if (!line_in && last_reg)
        begin
            if (phase_next == PH_CMD)
            begin
                main_tmr_next = load_val(cfg.sample_delay);
            end
            else if (phase_next == PH_ROM)
            begin
                if (bit_next == '0)
                    shift_next = (byte_next < 4'(ID_BYTES)) ? id_byte : IDLE_BYTE;
                drive_next = shift_next[0];
                shift_next = {1'b0, shift_next[7:1]};
                bit_next   = bit_next + 4'd1;
                if (bit_next == BITS_BYTE)
                begin
                    bit_next = '0;
                    if (byte_next != BYTE_CNT_MAX)
                        byte_next = byte_next + 4'd1;
                end
                main_tmr_next = load_val(cfg.read_hold);
            end
            rst_tmr_next = load_val(cfg.reset_low_min);
        end
        else if (line_in && !last_reg)
        begin
            if (phase_next == PH_RESET)
            begin
                phase_next    = PH_PWAIT;
                main_tmr_next = load_val(cfg.presence_wait);
            end
            rst_tmr_next = '0;
        end

        res.line_out = drive_next & line_in;
        res.phase    = phase_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            bit_reg      <= '0;
            byte_reg     <= '0;
            shift_reg    <= '0;
            last_reg     <= 1'b1;
            drive_reg    <= 1'b1;
            main_tmr_reg <= '0;
            rst_tmr_reg  <= '0;
        end
        else if (in_xfer)
        begin
            phase_reg    <= phase_next;
            bit_reg      <= bit_next;
            byte_reg     <= byte_next;
            shift_reg    <= shift_next;
            last_reg     <= last_next;
            drive_reg    <= drive_next;
            main_tmr_reg <= main_tmr_next;
            rst_tmr_reg  <= rst_tmr_next;
        end
    end

`ifndef SYNTHESIS
    a_bit_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_reg <= BITS_BYTE)
        else $error("bit count past one byte");

    a_fall_arms_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && !line_in && last_reg) |=> (rst_tmr_reg != '0))
        else $error("falling edge did not arm reset timer");

    a_rise_clears_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && line_in && !last_reg) |=> (rst_tmr_reg == '0))
        else $error("rising edge did not clear reset timer");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !in_xfer |=> $stable(phase_reg) && $stable(main_tmr_reg) && $stable(rst_tmr_reg))
        else $error("state moved without a transfer");
`endif

endmodule

`default_nettype wire

// ===== sv/owsid_outbuf.sv =====
`default_nettype none

module owsid_outbuf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire owsid_pkg::result_t push_data,
    output logic               can_push,
    output logic               out_valid,
    input  wire logic          out_ready,
    output owsid_pkg::result_t out_data
);
    import owsid_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    pop;

    assign pop      = out_valid_reg && out_ready;
    assign can_push = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_reg   <= skid_data_reg;
                skid_valid_reg <= 1'b0;
            end
        end
        else if (push)
        begin
            if (!out_valid_reg || pop)
            begin
                out_data_reg  <= push_data;
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_data_reg  <= push_data;
                skid_valid_reg <= 1'b1;
            end
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without output entry");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && pop) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not moved forward");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (push && out_valid_reg && !pop) |=> skid_valid_reg)
        else $error("transfer lost while output stalled");
`endif

endmodule

`default_nettype wire

// ===== sv/one_wire_serial_id_slave_unit.sv =====
// 1-Wire serial number slave, one bus tick per input transfer.
// Input channel: in_valid/in_ready carry line_in, the sampled bus level.
// Output channel: out_valid/out_ready carry line_out (slave drive ANDed with
// the bus) and phase (0 idle, 1 reset, 2 presence wait, 3 presence,
// 4 command, 5 read ROM). Every input transfer yields exactly one result.
// Without a stall, a tick's result is valid on the cycle after its transfer.
// Throughput: one tick per cycle while in_ready is high; the state update is
// a single registered pass, and a two-entry output buffer decouples the
// output channel. When the receiver stalls, a second result is held in the
// skid entry and in_ready drops until the receiver takes a result.
// Configuration: cfg_wr_en/cfg_addr/cfg_wdata write a register;
// index 0 sample_delay, 1 read_hold, 2 reset_low_min, 3 presence_wait,
// 4 presence_length, 5 read_rom_opcode, 6 id_code. Write only while idle.
// Reset (rst_n low, async): idle phase, bus seen high, drive released, both
// timers stopped, registers at their defaults, output buffer empty.
`default_nettype none

module one_wire_serial_id_slave_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             line_in,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic                                  line_out,
    output logic [2:0]                            phase,
    input  wire logic                             cfg_wr_en,
    input  wire logic [owsid_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [owsid_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import owsid_pkg::*;

    cfg_t    cfg;
    result_t res;
    result_t out_data;
    logic    in_xfer;
    logic    can_push;

    assign in_ready = can_push;
    assign in_xfer  = in_valid && can_push;

    owsid_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    owsid_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_xfer (in_xfer),
        .line_in (line_in),
        .cfg     (cfg),
        .res     (res)
    );

    owsid_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_xfer),
        .push_data (res),
        .can_push  (can_push),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign line_out = out_data.line_out;
    assign phase    = 3'(out_data.phase);

endmodule

`default_nettype wire
